// ===== sv/pulse_beat_detector_assert.svh =====
// Assertion macros for the pulse beat detector checker.
// Used by pbd_checker.sv; needs a clk and rst in the including scope.
`ifndef PULSE_BEAT_DETECTOR_ASSERT_SVH
`define PULSE_BEAT_DETECTOR_ASSERT_SVH

// same-cycle implication
`define PBD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pulse_beat_detector check failed");

// next-cycle implication
`define PBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pulse_beat_detector check failed");

`endif

// ===== sv/pbd_pkg.sv =====
// Shared types and constants of the pulse beat detector.
// No dependencies.
`default_nettype none
package pbd_pkg;

  localparam int SAMPLE_W = 24;
  localparam int TIME_W   = 32;
  localparam int THR_W    = 23;
  localparam int MS_W     = 16;
  localparam int CFG_W    = 23;
  localparam int IDX_W    = 3;
  localparam int DIV_W    = 49;
  localparam int DVS_W    = 32;

  localparam logic [IDX_W-1:0] REG_MIN_THR  = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAX_THR  = 3'd1;
  localparam logic [IDX_W-1:0] REG_STEP_RES = 3'd2;
  localparam logic [IDX_W-1:0] REG_INIT_HO  = 3'd3;
  localparam logic [IDX_W-1:0] REG_MASK_HO  = 3'd4;
  localparam logic [IDX_W-1:0] REG_INVALID  = 3'd5;
  localparam logic [IDX_W-1:0] REG_ALPHA    = 3'd6;
  localparam logic [IDX_W-1:0] REG_DECAY    = 3'd7;

  localparam logic [THR_W-1:0] RST_MIN_THR  = 23'd5120;
  localparam logic [THR_W-1:0] RST_MAX_THR  = 23'd204800;
  localparam logic [THR_W-1:0] RST_STEP_RES = 23'd7680;
  localparam logic [MS_W-1:0]  RST_INIT_HO  = 16'd2000;
  localparam logic [MS_W-1:0]  RST_MASK_HO  = 16'd200;
  localparam logic [MS_W-1:0]  RST_INVALID  = 16'd2000;
  localparam logic [MS_W-1:0]  RST_ALPHA    = 16'd39322;
  localparam logic [MS_W-1:0]  RST_DECAY    = 16'd64880;

  // (60000 << 16)
  localparam logic [DIV_W-1:0] RATE_NUM = 49'd3932160000;

  typedef enum logic [2:0] {
    PH_INIT   = 3'd0,
    PH_WAIT   = 3'd1,
    PH_FOLLOW = 3'd2,
    PH_MAYBE  = 3'd3,
    PH_MASK   = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    CT_IDLE,
    CT_EVAL,
    CT_MUL,
    CT_PERIOD,
    CT_LIN_START,
    CT_LIN_WAIT,
    CT_DECAY,
    CT_RATE_START,
    CT_RATE_WAIT,
    CT_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic mul;
    logic period_upd;
    logic div_start;
    logic div_rate;
    logic decay_apply;
    logic rate_apply;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic per_req;
    logic dec_req;
    logic linear;
    logic div_idle;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== sv/pbd_if.sv =====
// Valid/ready channel interfaces for samples and results.
// Uses pbd_pkg widths.
`default_nettype none
interface pbd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pbd_pkg::SAMPLE_W-1:0] sample_value;
  logic        [pbd_pkg::TIME_W-1:0]   time_ms;
  modport source (output valid, output sample_value, output time_ms, input ready);
  modport sink (input valid, input sample_value, input time_ms, output ready);
endinterface

interface pbd_out_if;
  logic                                valid;
  logic                                ready;
  logic                                beat_found;
  logic signed [pbd_pkg::SAMPLE_W-1:0] current_threshold;
  logic        [pbd_pkg::SAMPLE_W-1:0] filtered_period;
  logic        [pbd_pkg::SAMPLE_W-1:0] rate_bpm;
  logic        [2:0]                   detector_phase;
  modport source (output valid, output beat_found, output current_threshold,
                  output filtered_period, output rate_bpm, output detector_phase,
                  input ready);
  modport sink (input valid, input beat_found, input current_threshold,
                input filtered_period, input rate_bpm, input detector_phase,
                output ready);
endinterface
`default_nettype wire

// ===== sv/pbd_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Uses pbd_pkg widths.
`default_nettype none
module pbd_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [pbd_pkg::DIV_W-1:0]   dividend,
  input  wire logic [pbd_pkg::DVS_W-1:0]   divisor,
  output logic                             idle,
  output logic [pbd_pkg::DIV_W-1:0]        quotient
);
  localparam int CNT_W = $clog2(pbd_pkg::DIV_W + 1);

  logic [CNT_W-1:0]            cnt;
  logic [pbd_pkg::DVS_W-1:0]   rem;
  logic [pbd_pkg::DVS_W-1:0]   dvs;
  logic [pbd_pkg::DIV_W-1:0]   dvd;
  logic [pbd_pkg::DVS_W:0]     shifted;
  logic [pbd_pkg::DVS_W:0]     trial;

  assign shifted  = {rem, dvd[pbd_pkg::DIV_W-1]};
  assign trial    = shifted - {1'b0, dvs};
  assign idle     = (cnt == '0);
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(pbd_pkg::DIV_W);
    end else if (!idle) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      dvd <= dividend;
    end else if (!idle) begin
      if (!trial[pbd_pkg::DVS_W]) begin
        rem <= trial[pbd_pkg::DVS_W-1:0];
        dvd <= {dvd[pbd_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem <= shifted[pbd_pkg::DVS_W-1:0];
        dvd <= {dvd[pbd_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/pbd_ctrl.sv =====
// Sequencing state machine of the pulse beat detector.
// Uses pbd_pkg types; drives the datapath through cmd_t.
`default_nettype none
module pbd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pbd_pkg::status_t sts,
  output pbd_pkg::cmd_t         cmd
);
  pbd_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbd_pkg::CT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pbd_pkg::CT_IDLE:       if (in_valid) state_next = pbd_pkg::CT_EVAL;
      pbd_pkg::CT_EVAL:       state_next = pbd_pkg::CT_MUL;
      pbd_pkg::CT_MUL: begin
        if (sts.per_req) state_next = pbd_pkg::CT_PERIOD;
        else if (sts.dec_req && sts.linear) state_next = pbd_pkg::CT_LIN_START;
        else if (sts.dec_req) state_next = pbd_pkg::CT_DECAY;
        else state_next = pbd_pkg::CT_RATE_START;
      end
      pbd_pkg::CT_PERIOD:     state_next = pbd_pkg::CT_RATE_START;
      pbd_pkg::CT_LIN_START:  state_next = pbd_pkg::CT_LIN_WAIT;
      pbd_pkg::CT_LIN_WAIT:   if (sts.div_idle) state_next = pbd_pkg::CT_DECAY;
      pbd_pkg::CT_DECAY:      state_next = pbd_pkg::CT_RATE_START;
      pbd_pkg::CT_RATE_START: state_next = pbd_pkg::CT_RATE_WAIT;
      pbd_pkg::CT_RATE_WAIT:  if (sts.div_idle) state_next = pbd_pkg::CT_DONE;
      pbd_pkg::CT_DONE:       if (sts.out_free) state_next = pbd_pkg::CT_IDLE;
      default:                state_next = pbd_pkg::CT_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      pbd_pkg::CT_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      pbd_pkg::CT_EVAL:       cmd.eval = 1'b1;
      pbd_pkg::CT_MUL:        cmd.mul = 1'b1;
      pbd_pkg::CT_PERIOD:     cmd.period_upd = 1'b1;
      pbd_pkg::CT_LIN_START:  cmd.div_start = 1'b1;
      pbd_pkg::CT_DECAY:      cmd.decay_apply = 1'b1;
      pbd_pkg::CT_RATE_START: begin
        cmd.div_start = 1'b1;
        cmd.div_rate  = 1'b1;
      end
      pbd_pkg::CT_RATE_WAIT:  cmd.rate_apply = sts.div_idle;
      pbd_pkg::CT_DONE:       cmd.out_load = sts.out_free;
      default:                cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/pbd_datapath.sv =====
// Datapath: config registers, detector state, multipliers, output register.
// Uses pbd_pkg and pbd_div; commanded by pbd_ctrl.
`default_nettype none
module pbd_datapath #(
  parameter int FALLOFF_TARGET_Q16 = 19661,
  parameter int SAMPLE_PERIOD_MS   = 10
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [pbd_pkg::IDX_W-1:0]          cfg_index,
  input  wire logic [pbd_pkg::CFG_W-1:0]          cfg_data,
  input  wire logic signed [pbd_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic [pbd_pkg::TIME_W-1:0]         in_time,
  input  wire pbd_pkg::cmd_t                      cmd,
  output pbd_pkg::status_t                        sts,
  input  wire logic                               out_ready,
  output logic                                    out_valid,
  output logic                                    out_beat,
  output logic signed [pbd_pkg::SAMPLE_W-1:0]     out_thr,
  output logic [pbd_pkg::SAMPLE_W-1:0]            out_period,
  output logic [pbd_pkg::SAMPLE_W-1:0]            out_rate,
  output logic [2:0]                              out_phase
);
  localparam int K_W = 26;
  localparam logic [K_W-1:0] K_LIN = K_W'((65536 - FALLOFF_TARGET_Q16) * SAMPLE_PERIOD_MS);
  localparam int SW = pbd_pkg::SAMPLE_W;

  // configuration
  logic [pbd_pkg::THR_W-1:0] min_thr, max_thr, step_res;
  logic [pbd_pkg::MS_W-1:0]  init_ho, mask_ho, invalid_ms, alpha, decay_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_thr    <= pbd_pkg::RST_MIN_THR;
      max_thr    <= pbd_pkg::RST_MAX_THR;
      step_res   <= pbd_pkg::RST_STEP_RES;
      init_ho    <= pbd_pkg::RST_INIT_HO;
      mask_ho    <= pbd_pkg::RST_MASK_HO;
      invalid_ms <= pbd_pkg::RST_INVALID;
      alpha      <= pbd_pkg::RST_ALPHA;
      decay_f    <= pbd_pkg::RST_DECAY;
    end else if (cfg_we) begin
      case (cfg_index)
        pbd_pkg::REG_MIN_THR:  min_thr    <= cfg_data;
        pbd_pkg::REG_MAX_THR:  max_thr    <= cfg_data;
        pbd_pkg::REG_STEP_RES: step_res   <= cfg_data;
        pbd_pkg::REG_INIT_HO:  init_ho    <= cfg_data[pbd_pkg::MS_W-1:0];
        pbd_pkg::REG_MASK_HO:  mask_ho    <= cfg_data[pbd_pkg::MS_W-1:0];
        pbd_pkg::REG_INVALID:  invalid_ms <= cfg_data[pbd_pkg::MS_W-1:0];
        pbd_pkg::REG_ALPHA:    alpha      <= cfg_data[pbd_pkg::MS_W-1:0];
        pbd_pkg::REG_DECAY:    decay_f    <= cfg_data[pbd_pkg::MS_W-1:0];
        default:               min_thr    <= min_thr;
      endcase
    end
  end

  // detector state
  pbd_pkg::phase_t            phase, phase_next;
  logic signed [SW-1:0]       thr, thr_next;
  logic [SW-1:0]              period, period_next;
  logic signed [SW-1:0]       peak, peak_next;
  logic [pbd_pkg::TIME_W-1:0] last_time, last_time_next;
  logic [SW-1:0]              rate;

  // per-sample working registers
  logic signed [SW-1:0]       smp;
  logic [pbd_pkg::TIME_W-1:0] now;
  logic                       beat, beat_next;
  logic                       per_req, per_req_next;
  logic                       dec_req, dec_req_next;
  logic [15:0]                dlt, dlt_next;

  logic [pbd_pkg::TIME_W-1:0] since;
  logic signed [SW-1:0]       cap_s;
  logic signed [SW+1:0]       drop_sum;

  assign since    = now - last_time;
  assign cap_s    = (smp > $signed({1'b0, max_thr})) ? $signed({1'b0, max_thr}) : smp;
  assign drop_sum = (SW+2)'(smp) + $signed({3'b0, step_res});

  always_comb begin
    phase_next     = phase;
    thr_next       = thr;
    period_next    = period;
    peak_next      = peak;
    last_time_next = last_time;
    beat_next      = 1'b0;
    per_req_next   = 1'b0;
    dec_req_next   = 1'b0;
    dlt_next       = (since > 32'd65535) ? 16'hFFFF : since[15:0];
    case (phase)
      pbd_pkg::PH_INIT: if (now > {16'b0, init_ho}) phase_next = pbd_pkg::PH_WAIT;
      pbd_pkg::PH_WAIT: begin
        if (smp > thr) begin
          thr_next   = cap_s;
          phase_next = pbd_pkg::PH_FOLLOW;
        end
        if (since > {16'b0, invalid_ms}) begin
          period_next = '0;
          peak_next   = '0;
        end
        dec_req_next = 1'b1;
      end
      pbd_pkg::PH_FOLLOW: begin
        if (smp < thr) phase_next = pbd_pkg::PH_MAYBE;
        else thr_next = cap_s;
      end
      pbd_pkg::PH_MAYBE: begin
        if (drop_sum < (SW+2)'(thr)) begin
          beat_next      = 1'b1;
          peak_next      = smp;
          phase_next     = pbd_pkg::PH_MASK;
          per_req_next   = (dlt_next != '0);
          last_time_next = now;
        end else begin
          phase_next = pbd_pkg::PH_FOLLOW;
        end
      end
      pbd_pkg::PH_MASK: begin
        if (since > {16'b0, mask_ho}) phase_next = pbd_pkg::PH_WAIT;
        dec_req_next = 1'b1;
      end
      default: phase_next = pbd_pkg::PH_INIT;
    endcase
  end

  // products
  logic [39:0]        prod_a;
  logic [40:0]        prod_b;
  logic signed [40:0] prod_g;
  logic [pbd_pkg::DIV_W-1:0] prod_l;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_a <= 40'(alpha) * 40'({dlt, 8'b0});
      prod_b <= 41'(17'd65536 - {1'b0, alpha}) * 41'(period);
      prod_g <= 41'(thr) * $signed(41'({1'b0, decay_f}));
      prod_l <= pbd_pkg::DIV_W'(peak[SW-2:0]) * pbd_pkg::DIV_W'(K_LIN);
    end
  end

  // shared divider
  logic                      div_idle;
  logic [pbd_pkg::DIV_W-1:0] quot;

  pbd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cmd.div_rate ? pbd_pkg::RATE_NUM : prod_l),
    .divisor  (cmd.div_rate ? {8'b0, period} : {period, 8'b0}),
    .idle     (div_idle),
    .quotient (quot)
  );

  // period filter
  logic [41:0] per_sum;
  logic [25:0] per_new;
  assign per_sum = 42'(prod_a) + 42'(prod_b) + 42'd32768;
  assign per_new = per_sum[41:16];

  // threshold decay
  logic signed [40:0] g_adj;
  logic signed [26:0] g_val;
  logic [24:0]        q_sat;
  logic signed [26:0] t_val;
  logic signed [26:0] t_floor;

  assign g_adj   = prod_g + (prod_g[40] ? 41'sd65535 : 41'sd0);
  assign g_val   = 27'(g_adj >>> 16);
  assign q_sat   = (|quot[pbd_pkg::DIV_W-1:25]) ? '1 : quot[24:0];
  assign t_val   = sts.linear ? (27'(thr) - $signed({2'b0, q_sat})) : g_val;
  assign t_floor = $signed({4'b0, min_thr});

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= pbd_pkg::PH_INIT;
      thr       <= SW'(pbd_pkg::RST_MIN_THR);
      period    <= '0;
      peak      <= '0;
      last_time <= '0;
      rate      <= '0;
    end else begin
      if (cmd.eval) begin
        phase     <= phase_next;
        thr       <= thr_next;
        period    <= period_next;
        peak      <= peak_next;
        last_time <= last_time_next;
      end
      if (cmd.period_upd) begin
        period <= (|per_new[25:SW]) ? '1 : per_new[SW-1:0];
      end
      if (cmd.decay_apply) begin
        thr <= (t_val < t_floor) ? t_floor[SW-1:0] : t_val[SW-1:0];
      end
      if (cmd.rate_apply) begin
        if (period == '0) rate <= '0;
        else rate <= (|quot[pbd_pkg::DIV_W-1:SW]) ? '1 : quot[SW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      smp <= in_sample;
      now <= in_time;
    end
    if (cmd.eval) begin
      beat    <= beat_next;
      dlt     <= dlt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      per_req <= 1'b0;
      dec_req <= 1'b0;
    end else if (cmd.eval) begin
      per_req <= per_req_next;
      dec_req <= dec_req_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_beat   <= beat;
      out_thr    <= thr;
      out_period <= period;
      out_rate   <= rate;
      out_phase  <= phase;
    end
  end

  assign sts.per_req  = per_req;
  assign sts.dec_req  = dec_req;
  assign sts.linear   = (peak > 0) && (period != '0);
  assign sts.div_idle = div_idle;
  assign sts.out_free = !out_valid || out_ready;
endmodule
`default_nettype wire

// ===== sv/pulse_beat_detector.sv =====
// Pulse beat detector top level: controller, datapath, channel ports.
// Uses pbd_pkg, pbd_if, pbd_ctrl, pbd_datapath.
//
//  channel   dir  payload
//  samples   in   sample_value[23:0] s, time_ms[31:0]
//  results   out  beat_found, current_threshold, filtered_period, rate_bpm,
//                 detector_phase
//  cfg_*     in   cfg_index[2:0], cfg_data[22:0], write on cfg_we
//
// Linear-decay samples run two bit-serial divider passes, decay then rate;
// other samples run only the rate pass, with a period update, a decay step
// or neither before it.
// Reset is synchronous; config registers return to their defaults.
// A finished result waits in the result register while the next sample is
// taken; the block holds in its last step only while that register is full and not being read.
`default_nettype none
module pulse_beat_detector #(
  parameter int FALLOFF_TARGET_Q16 = 19661,
  parameter int SAMPLE_PERIOD_MS   = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [pbd_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [pbd_pkg::CFG_W-1:0]   cfg_data,
  pbd_in_if.sink                           samples,
  pbd_out_if.source                        results
);
  pbd_pkg::cmd_t    cmd;
  pbd_pkg::status_t sts;

  pbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pbd_datapath #(
    .FALLOFF_TARGET_Q16 (FALLOFF_TARGET_Q16),
    .SAMPLE_PERIOD_MS   (SAMPLE_PERIOD_MS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_sample  (samples.sample_value),
    .in_time    (samples.time_ms),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (results.ready),
    .out_valid  (results.valid),
    .out_beat   (results.beat_found),
    .out_thr    (results.current_threshold),
    .out_period (results.filtered_period),
    .out_rate   (results.rate_bpm),
    .out_phase  (results.detector_phase)
  );
endmodule
`default_nettype wire

// ===== sv/pbd_checker.sv =====
// Port-level checks for pulse_beat_detector, bound to the top level.
// Uses pulse_beat_detector_assert.svh.
`default_nettype none
`include "pulse_beat_detector_assert.svh"
module pbd_port_checks (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        beat_found,
  input wire logic [23:0] current_threshold,
  input wire logic [23:0] filtered_period,
  input wire logic [23:0] rate_bpm,
  input wire logic [2:0]  detector_phase
);
  `PBD_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready)
  `PBD_ASSERT_NOW(a_beat_masks, out_valid && beat_found, detector_phase == pbd_pkg::PH_MASK)
  `PBD_ASSERT_NOW(a_thr_nonneg, out_valid, !current_threshold[23])
  `PBD_ASSERT_NOW(a_rate_zero, out_valid && (filtered_period == 24'd0), rate_bpm == 24'd0)
  `PBD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
endmodule

bind pulse_beat_detector pbd_port_checks u_chk (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (samples.valid),
  .in_ready          (samples.ready),
  .out_valid         (results.valid),
  .out_ready         (results.ready),
  .beat_found        (results.beat_found),
  .current_threshold (results.current_threshold),
  .filtered_period   (results.filtered_period),
  .rate_bpm          (results.rate_bpm),
  .detector_phase    (results.detector_phase)
);
`default_nettype wire
